// ===== hdl/nq_pkg.sv =====
package nq_pkg;

    localparam int IN_FRAC_DEF   = 31;
    localparam int OUT_FRAC_DEF  = 26;
    localparam int NCOEF         = 11;
    localparam int LOG_STEPS     = 58;
    localparam int ISQ_STEPS     = 32;
    localparam int ISQ_PER_STAGE = 2;
    localparam int ISQ_STAGES    = ISQ_STEPS / ISQ_PER_STAGE;
    localparam int ROOT_FRAC     = 28;

    localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AC;
    localparam logic [63:0] MAG_MASK = 64'h3FFFFFFFFFFFFFFF;
    localparam logic [49:0] PQ_MAX   = '1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_SAT
    } t_status;

    typedef enum logic [2:0] {
        K_NORM,
        K_OVER,
        K_HALF,
        K_ZERO,
        K_ONE
    } t_kind;

    typedef struct packed {
        logic  valid;
        logic  upper;
        t_kind kind;
    } t_side;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] res;
    } t_isq;

    localparam logic [63:0] COEF_MANT [NCOEF] = '{
        64'd1570796288, 64'd3706987906, 64'd8364353589, 64'd2250947176,
        64'd6841218299, 64'd5824238515, 64'd104527497,  64'd8360937017,
        64'd3231081277, 64'd3657763036, 64'd6936233982
    };
    localparam int COEF_DEXP [NCOEF] = '{9, 11, 13, 13, 15, 15, 14, 17, 18, 20, 22};
    localparam logic COEF_NEG [NCOEF] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0
    };

    function automatic logic [63:0] coef_q48(input int i);
        logic [63:0] dv;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] bt;
        int          dexp;
        int          bexp;
        dv   = 64'd1;
        q    = '0;
        r    = '0;
        dexp = COEF_DEXP[i];
        bexp = 5 * i + 48 - dexp;
        for (int j = 0; j < dexp; j++) begin
            dv = dv * 64'd5;
        end
        for (int j = 0; j < 40 + bexp; j++) begin
            bt = (j < 40) ? ((COEF_MANT[i] >> (39 - j)) & 64'd1) : 64'd0;
            r  = (r << 1) | bt;
            q  = q << 1;
            if (r >= dv) begin
                r = r - dv;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= dv) begin
            q = q + 64'd1;
        end
        return COEF_NEG[i] ? (64'd0 - q) : q;
    endfunction

    localparam logic [63:0] COEF [NCOEF] = '{
        coef_q48(0), coef_q48(1), coef_q48(2), coef_q48(3), coef_q48(4), coef_q48(5),
        coef_q48(6), coef_q48(7), coef_q48(8), coef_q48(9), coef_q48(10)
    };

    function automatic logic [63:0] mh_sum(input logic [63:0] p00, input logic [63:0] p01,
                                           input logic [63:0] p10, input logic [63:0] p11);
        logic [34:0] mid;
        mid = 35'(p00[63:32]) + 35'(p01[31:0]) + 35'(p10[31:0]);
        return p11 + 64'(p01[63:32]) + 64'(p10[63:32]) + 64'(mid[34:32]);
    endfunction

    function automatic t_isq isq_step(input logic [63:0] x, input logic [63:0] res,
                                      input logic [63:0] bt);
        t_isq        o;
        logic [63:0] tr;
        tr = res + bt;
        if (x >= tr) begin
            o.x   = x - tr;
            o.res = (res >> 1) + bt;
        end else begin
            o.x   = x;
            o.res = res >> 1;
        end
        return o;
    endfunction

endpackage

// ===== hdl/nq_in_if.sv =====
interface nq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] prob;

    modport source (output valid, output prob, input ready);
    modport sink (input valid, input prob, output ready);
endinterface

// ===== hdl/nq_out_if.sv =====
interface nq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quantile;
    logic [1:0]         status;

    modport source (output valid, output quantile, output status, input ready);
    modport sink (input valid, input quantile, input status, output ready);
endinterface

// ===== hdl/normal_quantile.sv =====
// Throughput: one item per cycle while the output is not stalled, set by the fully
// pipelined log, Horner and root stages.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits but not the data registers.
module normal_quantile #(
    parameter int IN_FRAC_BITS  = nq_pkg::IN_FRAC_DEF,
    parameter int OUT_FRAC_BITS = nq_pkg::OUT_FRAC_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nq_in_if.sink     i_in,
    nq_out_if.source  o_res
);
    import nq_pkg::*;

    localparam int SH = ROOT_FRAC - OUT_FRAC_BITS;

    logic        en;
    logic [63:0] fr_m;
    logic [5:0]  fr_n;
    t_side       fr_side;
    logic [63:0] lg_w3;
    t_side       lg_side;
    logic [63:0] pl_acc;
    logic [63:0] pl_w3;
    t_side       pl_side;
    logic [31:0] rt_root;
    t_side       rt_side;
    logic [32:0] rnd;
    logic [31:0] mag_q;
    logic [31:0] n_quantile;
    t_status     n_status;
    logic        r_valid;
    logic [31:0] r_quantile;
    t_status     r_status;

    assign en         = !r_valid || o_res.ready;
    assign i_in.ready = en;

    nq_front #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_prob  (i_in.prob),
        .o_m     (fr_m),
        .o_n     (fr_n),
        .o_side  (fr_side)
    );

    nq_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_m     (fr_m),
        .i_n     (fr_n),
        .i_side  (fr_side),
        .o_w3    (lg_w3),
        .o_side  (lg_side)
    );

    nq_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_w3    (lg_w3),
        .i_side  (lg_side),
        .o_acc   (pl_acc),
        .o_w3    (pl_w3),
        .o_side  (pl_side)
    );

    nq_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (pl_acc),
        .i_w3    (pl_w3),
        .i_side  (pl_side),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    if (SH > 0) begin : g_round
        assign rnd = ({1'b0, rt_root} + (33'd1 << (SH - 1))) >> SH;
    end else begin : g_exact
        assign rnd = {1'b0, rt_root};
    end

    always_comb begin
        if (rt_side.upper) begin
            mag_q = (rnd > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
        end else begin
            mag_q = 32'd0 - ((rnd > 33'h0_8000_0000) ? 32'h8000_0000 : rnd[31:0]);
        end
    end

    always_comb begin
        unique case (rt_side.kind)
            K_NORM: begin
                n_quantile = mag_q;
                n_status   = ST_OK;
            end
            K_OVER: begin
                n_quantile = '0;
                n_status   = ST_RANGE;
            end
            K_HALF: begin
                n_quantile = '0;
                n_status   = ST_OK;
            end
            K_ZERO: begin
                n_quantile = 32'h8000_0000;
                n_status   = ST_SAT;
            end
            K_ONE: begin
                n_quantile = 32'h7FFF_FFFF;
                n_status   = ST_SAT;
            end
            default: begin
                n_quantile = '0;
                n_status   = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= rt_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quantile <= n_quantile;
            r_status   <= n_status;
        end
    end

    assign o_res.valid    = r_valid;
    assign o_res.quantile = r_quantile;
    assign o_res.status   = r_status;

`ifndef SYNTH
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_RANGE)) |-> (o_res.quantile == '0))
        else $error("out-of-range item with nonzero quantile");

    a_sat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_SAT)) |->
        ((o_res.quantile == 32'h8000_0000) || (o_res.quantile == 32'h7FFF_FFFF)))
        else $error("saturated item not at a range end");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");
`endif
endmodule

// ===== hdl/nq_front.sv =====
module nq_front #(
    parameter int IN_FRAC_BITS = nq_pkg::IN_FRAC_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_prob,
    output logic [63:0]   o_m,
    output logic [5:0]    o_n,
    output nq_pkg::t_side o_side
);
    import nq_pkg::*;

    localparam logic [31:0] ONE  = 32'(64'd1 << IN_FRAC_BITS);
    localparam logic [31:0] HALF = ONE >> 1;
    localparam int          WSH  = 32 - IN_FRAC_BITS;

    t_kind       kind;
    logic        upper;
    logic [31:0] n_w32;
    logic [64:0] prod;
    logic [63:0] n_u;
    logic [5:0]  n_lz;
    t_side       n_s0;
    t_side       r_s0, r_s1, r_s2, r_s3;
    logic [31:0] r_w32;
    logic [63:0] r_u1, r_u2, r_m;
    logic [5:0]  r_n2, r_n3;

    always_comb begin
        priority if (i_prob > ONE) begin
            kind = K_OVER;
        end else if (i_prob == HALF) begin
            kind = K_HALF;
        end else if (i_prob == '0) begin
            kind = K_ZERO;
        end else if (i_prob == ONE) begin
            kind = K_ONE;
        end else begin
            kind = K_NORM;
        end
    end

    assign upper = i_prob > HALF;
    assign n_w32 = (upper ? (ONE - i_prob) : i_prob) << WSH;
    assign n_s0  = '{valid: i_valid, upper: upper, kind: kind};

    assign prod = 65'(r_w32) * 65'(33'h1_0000_0000 - {1'b0, r_w32});
    assign n_u  = {prod[61:0], 2'b00};

    always_comb begin
        n_lz = 6'd63;
        for (int i = 0; i < 64; i++) begin
            if (r_u1[i]) begin
                n_lz = 6'(63 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (i_en) begin
            r_s0 <= n_s0;
            r_s1 <= r_s0;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w32 <= n_w32;
            r_u1  <= n_u;
            r_u2  <= r_u1;
            r_n2  <= n_lz;
            r_m   <= r_u2 << r_n2;
            r_n3  <= r_n2;
        end
    end

    assign o_m    = r_m;
    assign o_n    = r_n3;
    assign o_side = r_s3;
endmodule

// ===== hdl/nq_log.sv =====
module nq_log (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [63:0]   i_m,
    input  logic [5:0]    i_n,
    input  nq_pkg::t_side i_side,
    output logic [63:0]   o_w3,
    output nq_pkg::t_side o_side
);
    import nq_pkg::*;

    logic [63:0]          r_p00 [LOG_STEPS];
    logic [63:0]          r_p01 [LOG_STEPS];
    logic [63:0]          r_p11 [LOG_STEPS];
    logic [LOG_STEPS-1:0] r_fa  [LOG_STEPS];
    logic [5:0]           r_na  [LOG_STEPS];
    t_side                r_sa  [LOG_STEPS];
    logic [63:0]          r_m   [LOG_STEPS];
    logic [LOG_STEPS-1:0] r_fb  [LOG_STEPS];
    logic [5:0]           r_nb  [LOG_STEPS];
    t_side                r_sb  [LOG_STEPS];

    logic [63:0] lval;
    logic [63:0] r_l00, r_l01, r_l10, r_l11, r_w3;
    t_side       r_sl1, r_sl2;

    for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
        logic [63:0]          m_src;
        logic [LOG_STEPS-1:0] f_src;
        logic [5:0]           n_src;
        t_side                s_src;
        logic [63:0]          sq;

        if (j == 0) begin : g_head
            assign m_src = i_m;
            assign f_src = '0;
            assign n_src = i_n;
            assign s_src = i_side;
        end else begin : g_body
            assign m_src = r_m[j-1];
            assign f_src = r_fb[j-1];
            assign n_src = r_nb[j-1];
            assign s_src = r_sb[j-1];
        end

        assign sq = mh_sum(r_p00[j], r_p01[j], r_p01[j], r_p11[j]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa[j] <= '0;
                r_sb[j] <= '0;
            end else if (i_en) begin
                r_sa[j] <= s_src;
                r_sb[j] <= r_sa[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p00[j] <= 64'(m_src[31:0]) * 64'(m_src[31:0]);
                r_p01[j] <= 64'(m_src[31:0]) * 64'(m_src[63:32]);
                r_p11[j] <= 64'(m_src[63:32]) * 64'(m_src[63:32]);
                r_fa[j]  <= f_src;
                r_na[j]  <= n_src;
                r_fb[j]  <= {r_fa[j][LOG_STEPS-2:0], sq[63]};
                r_m[j]   <= sq[63] ? sq : (sq << 1);
                r_nb[j]  <= r_na[j];
            end
        end
    end

    assign lval = ((64'(r_nb[LOG_STEPS-1]) + 64'd1) << LOG_STEPS)
                - 64'(r_fb[LOG_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sl1 <= '0;
            r_sl2 <= '0;
        end else if (i_en) begin
            r_sl1 <= r_sb[LOG_STEPS-1];
            r_sl2 <= r_sl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l00 <= 64'(lval[31:0]) * 64'(LN2_Q64[31:0]);
            r_l01 <= 64'(lval[31:0]) * 64'(LN2_Q64[63:32]);
            r_l10 <= 64'(lval[63:32]) * 64'(LN2_Q64[31:0]);
            r_l11 <= 64'(lval[63:32]) * 64'(LN2_Q64[63:32]);
            r_w3  <= mh_sum(r_l00, r_l01, r_l10, r_l11);
        end
    end

    assign o_w3   = r_w3;
    assign o_side = r_sl2;
endmodule

// ===== hdl/nq_poly.sv =====
module nq_poly (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [63:0]   i_w3,
    input  nq_pkg::t_side i_side,
    output logic [63:0]   o_acc,
    output logic [63:0]   o_w3,
    output nq_pkg::t_side o_side
);
    import nq_pkg::*;

    localparam int NSTEP = NCOEF - 1;

    logic [63:0] r_p00 [NSTEP];
    logic [63:0] r_p01 [NSTEP];
    logic [63:0] r_p10 [NSTEP];
    logic [63:0] r_p11 [NSTEP];
    logic        r_neg [NSTEP];
    logic [63:0] r_wa  [NSTEP];
    t_side       r_sa  [NSTEP];
    logic [63:0] r_acc [NSTEP];
    logic [63:0] r_wb  [NSTEP];
    t_side       r_sb  [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_horner
        localparam int CI = NCOEF - 2 - k;

        logic [63:0] acc_src;
        logic [63:0] w_src;
        t_side       s_src;
        logic [63:0] mag;
        logic [63:0] t2;
        logic [63:0] prod;

        if (k == 0) begin : g_head
            assign acc_src = COEF[NCOEF-1];
            assign w_src   = i_w3;
            assign s_src   = i_side;
        end else begin : g_body
            assign acc_src = r_acc[k-1];
            assign w_src   = r_wb[k-1];
            assign s_src   = r_sb[k-1];
        end

        assign mag  = acc_src[63] ? (64'd0 - acc_src) : acc_src;
        assign t2   = w_src << 1;
        assign prod = mh_sum(r_p00[k], r_p01[k], r_p10[k], r_p11[k]) & MAG_MASK;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa[k] <= '0;
                r_sb[k] <= '0;
            end else if (i_en) begin
                r_sa[k] <= s_src;
                r_sb[k] <= r_sa[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p00[k] <= 64'(mag[31:0]) * 64'(t2[31:0]);
                r_p01[k] <= 64'(mag[31:0]) * 64'(t2[63:32]);
                r_p10[k] <= 64'(mag[63:32]) * 64'(t2[31:0]);
                r_p11[k] <= 64'(mag[63:32]) * 64'(t2[63:32]);
                r_neg[k] <= acc_src[63];
                r_wa[k]  <= w_src;
                r_acc[k] <= (r_neg[k] ? (64'd0 - prod) : prod) + COEF[CI];
                r_wb[k]  <= r_wa[k];
            end
        end
    end

    assign o_acc  = r_acc[NSTEP-1];
    assign o_w3   = r_wb[NSTEP-1];
    assign o_side = r_sb[NSTEP-1];
endmodule

// ===== hdl/nq_root.sv =====
module nq_root (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [63:0]   i_acc,
    input  logic [63:0]   i_w3,
    input  nq_pkg::t_side i_side,
    output logic [31:0]   o_root,
    output nq_pkg::t_side o_side
);
    import nq_pkg::*;

    logic        pos;
    logic [49:0] pq;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r_p00, r_p01, r_p10, r_p11, r_s;
    t_side       r_sa, r_sb;

    logic [63:0] r_x   [ISQ_STAGES];
    logic [63:0] r_res [ISQ_STAGES];
    t_side       r_sq  [ISQ_STAGES];

    assign pos = !i_acc[63] && (i_acc != '0);
    assign pq  = !pos ? '0 : ((i_acc[63:50] != '0) ? PQ_MAX : i_acc[49:0]);
    assign a   = {1'b0, pq, 13'd0};
    assign b   = i_w3 << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
            r_sb <= '0;
        end else if (i_en) begin
            r_sa <= i_side;
            r_sb <= r_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(a[31:0]) * 64'(b[31:0]);
            r_p01 <= 64'(a[31:0]) * 64'(b[63:32]);
            r_p10 <= 64'(a[63:32]) * 64'(b[31:0]);
            r_p11 <= 64'(a[63:32]) * 64'(b[63:32]);
            r_s   <= mh_sum(r_p00, r_p01, r_p10, r_p11);
        end
    end

    for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_isq
        logic [63:0] x_src;
        logic [63:0] res_src;
        t_side       s_src;
        t_isq        st [ISQ_PER_STAGE+1];

        if (k == 0) begin : g_head
            assign x_src   = r_s;
            assign res_src = '0;
            assign s_src   = r_sb;
        end else begin : g_body
            assign x_src   = r_x[k-1];
            assign res_src = r_res[k-1];
            assign s_src   = r_sq[k-1];
        end

        always_comb begin
            st[0] = '{x: x_src, res: res_src};
            for (int i = 0; i < ISQ_PER_STAGE; i++) begin
                st[i+1] = isq_step(st[i].x, st[i].res,
                                   64'd1 << (62 - 2 * (k * ISQ_PER_STAGE + i)));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k] <= '0;
            end else if (i_en) begin
                r_sq[k] <= s_src;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= st[ISQ_PER_STAGE].x;
                r_res[k] <= st[ISQ_PER_STAGE].res;
            end
        end
    end

    assign o_root = r_res[ISQ_STAGES-1][31:0];
    assign o_side = r_sq[ISQ_STAGES-1];
endmodule
